/* sv/mka_pkg.sv */
// Package: codes, register layout and the line-to-action table of the menu key autorepeat.
package mka_pkg;

   localparam int unsigned BTN_W  = 8;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned ACT_W  = 3;
   localparam int unsigned DLY_W  = 24;
   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;

   // action codes
   localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LEFT   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_RIGHT  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_UP     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DOWN   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_SELECT = 3'd5;
   localparam logic [ACT_W-1:0] ACT_EXIT   = 3'd6;
   localparam logic [ACT_W-1:0] ACT_BACK   = 3'd7;

   // repeat phases
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_INITIAL = 2'd1;
   localparam logic [1:0] PHASE_REPEAT  = 2'd2;

   // register indexes, taken from paddr[2]
   localparam logic REG_INITIAL_DELAY   = 1'b0;
   localparam logic REG_REPEAT_INTERVAL = 1'b1;

   localparam logic [DLY_W-1:0] INITIAL_DELAY_RST   = 24'd200000;
   localparam logic [DLY_W-1:0] REPEAT_INTERVAL_RST = 24'd50000;

   typedef struct packed {
      logic [DLY_W-1:0] initial_delay_us;
      logic [DLY_W-1:0] repeat_interval_us;
   } cfg_type;

   function automatic logic [ACT_W-1:0] line_action(input logic [2:0] line);
      logic [ACT_W-1:0] act;
      unique case (line)
         3'd0: act = ACT_LEFT;
         3'd1: act = ACT_RIGHT;
         3'd2: act = ACT_UP;
         3'd3: act = ACT_DOWN;
         3'd4: act = ACT_SELECT;
         3'd5: act = ACT_SELECT;
         3'd6: act = ACT_EXIT;
         default: act = ACT_BACK;
      endcase
      return act;
   endfunction

   // highest newly pressed line wins
   function automatic logic [ACT_W-1:0] pick_action(input logic [BTN_W-1:0] fresh);
      logic [ACT_W-1:0] act;
      act = ACT_NONE;
      for (int i = 0; i < BTN_W; i++) begin
         if (fresh[i]) begin
            act = line_action(3'(i));
         end
      end
      return act;
   endfunction

endpackage

/* sv/mka_if.sv */
// Interfaces: poll request channel and action response channel.
interface mka_req_if;
   logic                         valid;
   logic                         ready;
   logic [mka_pkg::BTN_W-1:0]    buttons_now;
   logic [mka_pkg::TIME_W-1:0]   time_now_us;

   modport source (output valid, output buttons_now, output time_now_us, input ready);
   modport sink   (input valid, input buttons_now, input time_now_us, output ready);
endinterface

interface mka_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mka_pkg::ACT_W-1:0]    action;
   logic                         is_repeat;

   modport source (output valid, output action, output is_repeat, input ready);
   modport sink   (input valid, input action, input is_repeat, output ready);
endinterface

/* sv/menu_key_autorepeat.sv */
// Top level: poll input register, autorepeat core, action output register, APB settings.
//
//   channel   dir   handshake            beat contents
//   req_ch    in    valid/ready          buttons_now[7:0], time_now_us[31:0]
//   rsp_ch    out   valid/ready          action[2:0], is_repeat
//   csr_*     in    APB setup/access     initial_delay_us @0x0, repeat_interval_us @0x4
//
// One poll per cycle sustained while rsp_ch is ready; a taken poll passes the input register
// and then the result register before its action is offered, behind the one subtract and
// two compares in the core. Synchronous active-high reset clears both stage valids and the
// core state; settings return to 200000 us and 50000 us. A stalled rsp_ch holds the result
// register; the input register keeps taking one more beat until it too is full.
module menu_key_autorepeat (
   input  logic                         clock,
   input  logic                         reset,
   mka_req_if.sink                      req_ch,
   mka_rsp_if.source                    rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mka_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mka_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [mka_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);

   mka_pkg::cfg_type cfg;

   logic                       in_valid_ff;
   logic [mka_pkg::BTN_W-1:0]  in_btn_ff;
   logic [mka_pkg::TIME_W-1:0] in_time_ff;
   logic                       out_valid_ff;
   logic [mka_pkg::ACT_W-1:0]  out_act_ff;
   logic                       out_rep_ff;

   logic                       out_load;
   logic                       in_take;
   logic [mka_pkg::ACT_W-1:0]  core_act;
   logic                       core_rep;

   mka_cfg_regs u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // advance the input beat when the result register is free or draining
   assign out_load     = in_valid_ff & (~out_valid_ff | rsp_ch.ready);
   assign in_take      = req_ch.valid & req_ch.ready;
   assign req_ch.ready = ~in_valid_ff | out_load;

   mka_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .load        (out_load),
      .buttons_now (in_btn_ff),
      .time_now_us (in_time_ff),
      .action      (core_act),
      .is_repeat   (core_rep)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            in_valid_ff <= 1'b1;
         end else if (out_load) begin
            in_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_btn_ff  <= req_ch.buttons_now;
         in_time_ff <= req_ch.time_now_us;
      end
      if (out_load) begin
         out_act_ff <= core_act;
         out_rep_ff <= core_rep;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.action    = out_act_ff;
   assign rsp_ch.is_repeat = out_rep_ff;

   a_rep_has_action: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_repeat |-> rsp_ch.action != mka_pkg::ACT_NONE)
      else $error("repeat flagged with no action");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("poll taken with both stages full");

   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff)
      else $error("result register not valid after load");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !out_valid_ff)
      else $error("stages not empty after reset");

endmodule

/* sv/mka_cfg_regs.sv */
// APB register file for the delay and interval settings.
module mka_cfg_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mka_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mka_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [mka_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output mka_pkg::cfg_type             cfg
);

   logic [mka_pkg::DLY_W-1:0] init_ff, init_in;
   logic [mka_pkg::DLY_W-1:0] intv_ff, intv_in;
   logic                      wr_en;
   logic                      reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      init_in = init_ff;
      intv_in = intv_ff;
      if (wr_en) begin
         unique case (reg_sel)
            mka_pkg::REG_INITIAL_DELAY:   init_in = csr_pwdata[mka_pkg::DLY_W-1:0];
            mka_pkg::REG_REPEAT_INTERVAL: intv_in = csr_pwdata[mka_pkg::DLY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= mka_pkg::INITIAL_DELAY_RST;
         intv_ff <= mka_pkg::REPEAT_INTERVAL_RST;
      end else begin
         init_ff <= init_in;
         intv_ff <= intv_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         mka_pkg::REG_INITIAL_DELAY:
            csr_prdata = {{(mka_pkg::DATA_W-mka_pkg::DLY_W){1'b0}}, init_ff};
         default:
            csr_prdata = {{(mka_pkg::DATA_W-mka_pkg::DLY_W){1'b0}}, intv_ff};
      endcase
   end

   assign cfg.initial_delay_us   = init_ff;
   assign cfg.repeat_interval_us = intv_ff;

endmodule

/* sv/mka_core.sv */
// Edge detect, priority pick and repeat timer with the per-poll state.
module mka_core (
   input  logic                         clock,
   input  logic                         reset,
   input  mka_pkg::cfg_type             cfg,
   input  logic                         load,
   input  logic [mka_pkg::BTN_W-1:0]    buttons_now,
   input  logic [mka_pkg::TIME_W-1:0]   time_now_us,
   output logic [mka_pkg::ACT_W-1:0]    action,
   output logic                         is_repeat
);

   logic [mka_pkg::BTN_W-1:0]  prev_ff, prev_in;
   logic [mka_pkg::BTN_W-1:0]  mask_ff, mask_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [mka_pkg::TIME_W-1:0] last_ff, last_in;
   logic [mka_pkg::ACT_W-1:0]  ract_ff, ract_in;

   logic [mka_pkg::BTN_W-1:0]  fresh;
   logic [mka_pkg::ACT_W-1:0]  new_act;
   logic [mka_pkg::TIME_W-1:0] elapsed;
   logic                       held;
   logic                       init_due;
   logic                       intv_due;

   assign fresh    = buttons_now & ~prev_ff;
   assign new_act  = mka_pkg::pick_action(fresh);
   assign elapsed  = time_now_us - last_ff;
   assign held     = |(buttons_now & mask_ff);
   assign init_due = elapsed > {{(mka_pkg::TIME_W-mka_pkg::DLY_W){1'b0}}, cfg.initial_delay_us};
   assign intv_due = elapsed > {{(mka_pkg::TIME_W-mka_pkg::DLY_W){1'b0}}, cfg.repeat_interval_us};

   always_comb begin
      action    = new_act;
      is_repeat = 1'b0;
      prev_in   = buttons_now;
      mask_in   = mask_ff;
      phase_in  = phase_ff;
      last_in   = last_ff;
      ract_in   = ract_ff;
      priority if (new_act != mka_pkg::ACT_NONE) begin
         last_in  = time_now_us;
         phase_in = mka_pkg::PHASE_INITIAL;
         mask_in  = fresh;
         ract_in  = new_act;
      end else if (held) begin
         // first repeat restarts the timer, so the interval check cannot fire too
         if (phase_ff == mka_pkg::PHASE_INITIAL && init_due) begin
            action    = ract_ff;
            is_repeat = 1'b1;
            last_in   = time_now_us;
            phase_in  = mka_pkg::PHASE_REPEAT;
         end else if (phase_ff == mka_pkg::PHASE_REPEAT && intv_due) begin
            action    = ract_ff;
            is_repeat = 1'b1;
            last_in   = time_now_us;
         end
      end
      if (action == mka_pkg::ACT_NONE) begin
         is_repeat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         mask_ff  <= '0;
         phase_ff <= mka_pkg::PHASE_IDLE;
         last_ff  <= '0;
         ract_ff  <= mka_pkg::ACT_NONE;
      end else if (load) begin
         prev_ff  <= prev_in;
         mask_ff  <= mask_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
         ract_ff  <= ract_in;
      end
   end

endmodule
